// ----- src/calendar_date_to_julian_day_defines.svh -----
// Assertion macros for the calendar date to Julian day block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef CALENDAR_DATE_TO_JULIAN_DAY_DEFINES_SVH
`define CALENDAR_DATE_TO_JULIAN_DAY_DEFINES_SVH
`ifndef SYNTHESIS
`define CDJD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cdjd: same-cycle check failed");
`define CDJD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cdjd: next-cycle check failed");
`else
`define CDJD_ASSERT_IMP(label, ante, cons)
`define CDJD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/cdjd_pkg.sv -----
// Shared types and constants for the calendar date to Julian day pipeline.
// No dependencies.
package cdjd_pkg;

  localparam int unsigned NumStages = 6;

  localparam int unsigned YearW  = 15;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned JdnW   = 23;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned DowW   = 3;

  localparam int unsigned YadjW = 16;
  localparam int unsigned SumW  = 26;
  localparam int unsigned DmW   = 9;
  localparam int unsigned CentW = 8;
  localparam int unsigned BW    = 9;
  localparam int unsigned WkW   = 24;

  localparam logic [MonthW-1:0] MonthJan    = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb    = 4'd2;
  localparam logic [MonthW-1:0] MonthWrap   = 4'd12;
  localparam logic [MonthW-1:0] MonthJanAdj = 4'd13;

  localparam logic signed [YadjW-1:0] GregYear  = 16'sd1582;
  localparam logic [MonthW-1:0]       GregMonth = 4'd10;
  localparam logic [DayW-1:0]         GregDay   = 5'd15;

  // floor(30.6001 * (m + 1)) for adjusted month m
  localparam logic [DmW-1:0] DmTable [16] = '{
    9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
    9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd489
  };

  localparam logic signed [27:0] YearDays4 = 28'sd1461;
  localparam logic [26:0]        Div100Mul = 27'd5243;
  localparam int unsigned        Div100Sh  = 19;

  localparam logic signed [YadjW-1:0] Year25Bias = 16'sd16400;
  localparam logic [15:0]             Inv25      = 16'd23593;
  localparam logic [15:0]             Div25Limit = 16'd2621;

  localparam logic [SumW-1:0] JdnOffset = 26'd1720995;
  // One, shifted up by a multiple of seven
  localparam logic [WkW-1:0]  WeekBias  = 24'd7340033;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] valid;
  } pipe_ctrl_t;

endpackage

// ----- src/calendar_date_to_julian_day.sv -----
// Calendar date to Julian day number, six-stage pipeline.
// Depends on cdjd_pkg, cdjd_pipe_ctrl and calendar_date_to_julian_day_defines.svh.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------------
//   in      | in_valid_i/in_ready_o   | year_i, month_i, day_i
//   out     | out_valid_o/out_ready_i | julian_day_number_o, day_of_year_o,
//           |                        | day_of_week_o, leap_year_o
//
// Each date moves through s1_q to s6_q; one date per cycle while out_ready_i is high.
// The stage count is set by the 1461 and 1/100 multipliers, the sum adders and
// the two-step mod-7 fold of the weekday.
// Reset clears the valid bits only; data registers load when their stage advances.
// A stall at the output holds every full stage; bubbles are squeezed out.
`include "calendar_date_to_julian_day_defines.svh"
module calendar_date_to_julian_day import cdjd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [YearW-1:0] year_i,
  input  logic [MonthW-1:0]       month_i,
  input  logic [DayW-1:0]         day_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [JdnW-1:0]         julian_day_number_o,
  output logic [DoyW-1:0]         day_of_year_o,
  output logic [DowW-1:0]         day_of_week_o,
  output logic                    leap_year_o
);

  typedef struct packed {
    logic signed [YadjW-1:0] y_adj;
    logic signed [YadjW-1:0] y0;
    logic [DmW-1:0]          dm;
    logic [DayW-1:0]         day;
    logic                    greg;
    logic                    greg0;
    logic [15:0]             prod25;
    logic                    div4;
    logic                    div16;
  } s1_t;

  typedef struct packed {
    logic [SumW-1:0]  c;
    logic [SumW-1:0]  c0;
    logic [CentW-1:0] a;
    logic [CentW-1:0] a0;
    logic             greg;
    logic             greg0;
    logic [DmW-1:0]   dm;
    logic [DayW-1:0]  day;
    logic             leap;
  } s2_t;

  typedef struct packed {
    logic [BW-1:0]   b;
    logic [BW-1:0]   b0;
    logic [SumW-1:0] p;
    logic [SumW-1:0] p0;
    logic            leap;
  } s3_t;

  typedef struct packed {
    logic [SumW-1:0] j;
    logic [DoyW-1:0] j0;
    logic            leap;
  } s4_t;

  typedef struct packed {
    logic [JdnW-1:0] jdn;
    logic [DoyW-1:0] doy;
    logic [5:0]      fold;
    logic            leap;
  } s5_t;

  typedef struct packed {
    logic [JdnW-1:0] jdn;
    logic [DoyW-1:0] doy;
    logic [DowW-1:0] dow;
    logic            leap;
  } s6_t;

  pipe_ctrl_t ctrl;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;

  cdjd_pipe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .ctrl_o  (ctrl)
  );

  // Stage 1: shift Jan/Feb to the prior year, pick the Gregorian side, month term, leap tests
  logic signed [YadjW-1:0] year_ext;
  logic                    early;
  logic [MonthW-1:0]       m_adj;
  logic [15:0]             x25;
  logic [31:0]             p25;

  always_comb begin
    year_ext   = 16'(year_i);
    early      = (month_i == MonthJan) || (month_i == MonthFeb);
    m_adj      = early ? month_i + MonthWrap : month_i;
    s1_d.y_adj = early ? year_ext - 16'sd1 : year_ext;
    s1_d.y0    = year_ext - 16'sd1;
    s1_d.dm    = DmTable[m_adj];
    s1_d.day   = day_i;
    s1_d.greg  = (s1_d.y_adj > GregYear) ||
                 ((s1_d.y_adj == GregYear) &&
                  ((m_adj > GregMonth) || ((m_adj == GregMonth) && (day_i >= GregDay))));
    s1_d.greg0 = s1_d.y0 >= GregYear;
    x25        = 16'(year_ext + Year25Bias);
    p25        = 32'(x25) * 32'(Inv25);
    s1_d.prod25 = p25[15:0];
    s1_d.div4  = year_i[1:0] == 2'd0;
    s1_d.div16 = year_i[3:0] == 4'd0;
  end

  // Stage 2: year term floor(1461*y/4), century y/100 and the leap flag
  logic signed [27:0] cprod, cprod0;
  logic [26:0]        aprod, aprod0;

  always_comb begin
    cprod      = 28'(s1_q.y_adj) * YearDays4;
    cprod0     = 28'(s1_q.y0) * YearDays4;
    aprod      = 27'(s1_q.y_adj[13:0]) * Div100Mul;
    aprod0     = 27'(s1_q.y0[13:0]) * Div100Mul;
    s2_d.c     = cprod[27:2];
    s2_d.c0    = cprod0[27:2];
    s2_d.a     = aprod[Div100Sh +: CentW];
    s2_d.a0    = aprod0[Div100Sh +: CentW];
    s2_d.greg  = s1_q.greg;
    s2_d.greg0 = s1_q.greg0;
    s2_d.dm    = s1_q.dm;
    s2_d.day   = s1_q.day;
    s2_d.leap  = s1_q.div4 && !((s1_q.prod25 <= Div25Limit) && !s1_q.div16);
  end

  // Stage 3: Gregorian correction and partial sums
  always_comb begin
    s3_d.b    = s2_q.greg ?
                (9'd2 - {1'b0, s2_q.a} + {3'b000, s2_q.a[7:2]}) : '0;
    s3_d.b0   = s2_q.greg0 ?
                (9'd2 - {1'b0, s2_q.a0} + {3'b000, s2_q.a0[7:2]}) : '0;
    s3_d.p    = s2_q.c + 26'(s2_q.dm) + 26'(s2_q.day) + JdnOffset;
    s3_d.p0   = s2_q.c0 + 26'(DmTable[MonthJanAdj]) + JdnOffset;
    s3_d.leap = s2_q.leap;
  end

  // Stage 4: full day numbers
  logic [SumW-1:0] j0_full;

  always_comb begin
    s4_d.j    = s3_q.p + {{(SumW-BW){s3_q.b[BW-1]}}, s3_q.b};
    j0_full   = s3_q.p0 + {{(SumW-BW){s3_q.b0[BW-1]}}, s3_q.b0};
    s4_d.j0   = j0_full[DoyW-1:0];
    s4_d.leap = s3_q.leap;
  end

  // Stage 5: day of year, weekday octal digit sum
  logic [WkW-1:0] wk;

  always_comb begin
    wk        = s4_q.j[WkW-1:0] + WeekBias;
    s5_d.fold = '0;
    for (int i = 0; i < WkW / 3; i++) begin
      s5_d.fold = s5_d.fold + 6'(wk[3*i +: 3]);
    end
    s5_d.jdn  = s4_q.j[JdnW-1:0];
    s5_d.doy  = s4_q.j[DoyW-1:0] - s4_q.j0;
    s5_d.leap = s4_q.leap;
  end

  // Stage 6: finish mod 7
  logic [3:0] fold2;

  always_comb begin
    fold2 = 4'(s5_q.fold[5:3]) + 4'(s5_q.fold[2:0]);
    priority if (fold2 >= 4'd14) begin
      s6_d.dow = '0;
    end else if (fold2 >= 4'd7) begin
      s6_d.dow = 3'(fold2 - 4'd7);
    end else begin
      s6_d.dow = fold2[2:0];
    end
    s6_d.jdn  = s5_q.jdn;
    s6_d.doy  = s5_q.doy;
    s6_d.leap = s5_q.leap;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) s1_q <= s1_d;
    if (ctrl.en[1]) s2_q <= s2_d;
    if (ctrl.en[2]) s3_q <= s3_d;
    if (ctrl.en[3]) s4_q <= s4_d;
    if (ctrl.en[4]) s5_q <= s5_d;
    if (ctrl.en[5]) s6_q <= s6_d;
  end

  assign julian_day_number_o = s6_q.jdn;
  assign day_of_year_o       = s6_q.doy;
  assign day_of_week_o       = s6_q.dow;
  assign leap_year_o         = s6_q.leap;

  `CDJD_ASSERT_IMP(a_dow_range, out_valid_o, day_of_week_o <= 3'd6)
  `CDJD_ASSERT_IMP(a_empty_takes, ctrl.valid == '0, in_ready_o)
  `CDJD_ASSERT_IMP(a_full_stall, (&ctrl.valid) && !out_ready_i, !in_ready_o)
  `CDJD_ASSERT_NXT(a_transfer_enters, in_valid_i && in_ready_o, ctrl.valid[0])

endmodule

// ----- src/cdjd_pipe_ctrl.sv -----
// Valid/ready control for the date pipeline: per-stage valid bits and load enables.
// Depends on cdjd_pkg.
module cdjd_pipe_ctrl import cdjd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  output logic       valid_o,
  input  logic       ready_i,
  output pipe_ctrl_t ctrl_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages:0]   ready;
  logic [NumStages-1:0] up_valid;

  assign up_valid = {valid_q[NumStages-2:0], valid_i};

  always_comb begin
    ready[NumStages] = ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      valid_d[k] = ready[k] ? up_valid[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ready_o      = ready[0];
  assign valid_o      = valid_q[NumStages-1];
  assign ctrl_o.en    = ready[NumStages-1:0];
  assign ctrl_o.valid = valid_q;

endmodule
